/* design/equity_curve_risk_metrics_macros.svh */
// Assertion macros shared by the risk metrics checker.
`ifndef EQUITY_CURVE_RISK_METRICS_MACROS_SVH
`define EQUITY_CURVE_RISK_METRICS_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ECRM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ECRM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ecrm_pkg.sv */
// Shared widths, constants and types of the equity-curve risk metrics block.
package ecrm_pkg;

    localparam int unsigned EQ_W     = 40;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CNT_W    = 17;
    localparam int unsigned SUM_W    = 48;
    localparam int unsigned SQ_W     = 64;
    localparam int unsigned DD_W     = 25;
    localparam int unsigned TR_W     = 32;
    localparam int unsigned SH_W     = 32;
    localparam int unsigned RET_W    = 24;
    localparam int unsigned SQR_W    = 2 * RET_W;
    localparam int unsigned FRAC_W   = 24;
    localparam int unsigned RFRAC_W  = 16;

    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 96;
    localparam int unsigned M_TUSER_W  = 1;
    localparam int unsigned DD_LO      = TR_W;
    localparam int unsigned DD_HI      = TR_W + DD_W - 1;
    localparam int unsigned M_PAD_LSB  = TR_W + DD_W + SH_W;

    localparam int unsigned DVD_W   = 128;
    localparam int unsigned DSR_W   = 81;
    localparam int unsigned QUO_W   = 64;
    localparam int unsigned STEP_W  = 8;
    localparam int unsigned MUL_W   = 96;
    localparam int unsigned MCNT_W  = 6;
    localparam int unsigned NQ_W    = 81;
    localparam int unsigned RT_W    = 63;

    localparam logic [STEP_W-1:0] DIV_SHORT_STEPS = 8'd64;
    localparam logic [STEP_W-1:0] DIV_LONG_STEPS  = 8'd160;

    localparam int unsigned MAX_SAMPLES_DEF = 65536;
    localparam int unsigned CNT_CAP         = (1 << CNT_W) - 1;

    localparam logic [EQ_W-1:0]  CAP_RESET = 40'd25600000;
    localparam logic [RET_W-1:0] RET_MAX   = '1;
    localparam logic [SUM_W-1:0] SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [TR_W-1:0]  TR_MAX    = {1'b0, {(TR_W-1){1'b1}}};
    localparam logic [SH_W-1:0]  SH_MAX    = {1'b0, {(SH_W-1){1'b1}}};
    localparam logic [SH_W-1:0]  SH_MIN    = {1'b1, {(SH_W-1){1'b0}}};
    localparam logic [DD_W-1:0]  DD_ONE    = {1'b1, {(DD_W-1){1'b0}}};

    localparam logic [MODE_W-1:0] MODE_SAMPLE     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FINAL      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH     = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FINISH_ALT = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SAMPLE,
        ST_RDIV,
        ST_ACC,
        ST_SQADD,
        ST_DD,
        ST_DDIV,
        ST_COMMIT,
        ST_FIN,
        ST_TDIV,
        ST_SHARPE,
        ST_MUL1,
        ST_MUL2,
        ST_DIFF,
        ST_SDIV,
        ST_SQRT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
        logic long_run;
    } div_ctl_t;

    typedef struct packed {
        logic done;
        logic big;
    } div_sts_t;

endpackage

/* design/ecrm_div.sv */
// Bit-serial restoring divider shared by all quotients of the block.
module ecrm_div import ecrm_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  div_ctl_t         ctl,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output div_sts_t         sts,
    output logic [QUO_W-1:0] quotient
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              big_reg, big_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;

    logic [DSR_W:0]    shifted;
    logic [DSR_W:0]    trial;
    logic              fits;

    assign shifted = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial   = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        big_next  = big_reg;
        step_next = step_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            big_next  = 1'b0;
            step_next = ctl.long_run ? DIV_LONG_STEPS : DIV_SHORT_STEPS;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end else if (busy_reg) begin
            rem_next  = fits ? trial[DSR_W-1:0] : shifted[DSR_W-1:0];
            quo_next  = {quo_reg[QUO_W-2:0], fits};
            big_next  = big_reg | quo_reg[QUO_W-1] | quo_reg[QUO_W-2] | quo_reg[QUO_W-3];
            dvd_next  = {dvd_reg[DVD_W-2:0], 1'b0};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        big_reg <= big_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign sts.done = done_reg;
    assign sts.big  = big_reg;
    assign quotient = quo_reg;

endmodule

/* design/equity_curve_risk_metrics.sv */
// Top level: running peak, drawdown, return sums and final risk figures.
//
//  channel | dir | tdata                   | tuser      | tlast
//  s_      | in  | equity                  | mode       | -
//  m_      | out | tot_ret, max_dd,        | div_fault  | -
//          |     | sharpe                  |            |
//  cfg_    | in  | start capital           | -          | -
//
// A sample with a return uses two 64-step passes of the shared restoring
// divider, then accumulation.
// A finish can add divider passes (64 and 160 steps), shift-add
// multiplier (17 and 48 steps) and a 32-step square root.
// Reset is synchronous; no clearing pass follows it.
// One item is in work at a time; a waiting result blocks the input only once the next result is ready to be sent.
module equity_curve_risk_metrics import ecrm_pkg::*; #(
    parameter int unsigned MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [39:0] equity
    input  logic [MODE_W-1:0]    s_tuser,   // [1:0] mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] tot_ret, [56:32] max_dd,
                                            // [88:57] sharpe, [95:89] zero
    output logic [M_TUSER_W-1:0] m_tuser,   // [0] div_fault
    input  logic                 cfg_wr_en,
    input  logic [EQ_W-1:0]      cfg_wr_data
);

    localparam int unsigned CNT_LIMIT_I =
        (MAX_SAMPLES - 1 > CNT_CAP) ? CNT_CAP : MAX_SAMPLES - 1;
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(CNT_LIMIT_I);

    state_t               state_reg, state_next;
    logic [EQ_W-1:0]      cap_reg, cap_next;
    logic [EQ_W-1:0]      peak_reg, peak_next;
    logic [EQ_W-1:0]      prev_reg, prev_next;
    logic                 have_reg, have_next;
    logic [DD_W-1:0]      worst_reg, worst_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [SQ_W-1:0]      sq_reg, sq_next;
    logic                 pfault_reg, pfault_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    logic [MODE_W-1:0]    mode_reg, mode_next;
    logic [EQ_W-1:0]      eq_reg, eq_next;
    logic                 rneg_reg, rneg_next;
    logic [RET_W-1:0]     mag_reg, mag_next;
    logic [SQR_W-1:0]     sqr_reg, sqr_next;
    logic [TR_W-1:0]      tr_reg, tr_next;
    logic [SH_W-1:0]      sh_reg, sh_next;
    logic                 fault_reg, fault_next;
    logic                 sneg_reg, sneg_next;
    logic [NQ_W-1:0]      nq_reg, nq_next;
    logic [MUL_W-1:0]     mul_acc_reg, mul_acc_next;
    logic [SQ_W-1:0]      mul_cand_reg, mul_cand_next;
    logic [SUM_W-1:0]     mul_plr_reg, mul_plr_next;
    logic [MCNT_W-1:0]    mul_cnt_reg, mul_cnt_next;
    logic [RT_W-1:0]      rt_x_reg, rt_x_next;
    logic [RT_W-1:0]      rt_res_reg, rt_res_next;
    logic [RT_W-1:0]      rt_bit_reg, rt_bit_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0] m_tuser_reg, m_tuser_next;

    div_ctl_t             div_ctl;
    div_sts_t             div_sts;
    logic [DVD_W-1:0]     div_dvd;
    logic [DSR_W-1:0]     div_dsr;
    logic [QUO_W-1:0]     div_q;

    logic                 clear_run;
    logic                 eq_lt_prev;
    logic [EQ_W-1:0]      ret_diff;
    logic [EQ_W-1:0]      dd_d;
    logic                 fin_neg;
    logic [EQ_W-1:0]      fin_mag;
    logic [RET_W-1:0]     ret_mag;
    logic [SUM_W:0]       ret_ext;
    logic [SUM_W:0]       sum_wide;
    logic [SUM_W-1:0]     sum_sat;
    logic [SQ_W:0]        sq_wide;
    logic [SQ_W-1:0]      sq_sat;
    logic [SUM_W-1:0]     smag;
    logic [MUL_W:0]       nq_diff;
    logic [MUL_W+7:0]     b_val;
    logic [RT_W-1:0]      rt_trial;
    logic [TR_W-1:0]      tr_val;

    ecrm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .sts      (div_sts),
        .quotient (div_q)
    );

    assign eq_lt_prev = eq_reg < prev_reg;
    assign ret_diff   = eq_lt_prev ? prev_reg - eq_reg : eq_reg - prev_reg;
    assign dd_d       = peak_reg - eq_reg;
    assign fin_neg    = prev_reg < cap_reg;
    assign fin_mag    = fin_neg ? cap_reg - prev_reg : prev_reg - cap_reg;

    assign ret_mag = (!rneg_reg && div_q[QUO_W-1:RET_W] != '0) ? RET_MAX : div_q[RET_W-1:0];
    assign ret_ext = rneg_reg ? -((SUM_W+1)'(mag_reg)) : (SUM_W+1)'(mag_reg);
    assign sum_wide = {sum_reg[SUM_W-1], sum_reg} + ret_ext;
    assign sum_sat = (sum_wide[SUM_W] != sum_wide[SUM_W-1])
                   ? (sum_wide[SUM_W] ? SUM_MIN : SUM_MAX) : sum_wide[SUM_W-1:0];
    assign sq_wide = {1'b0, sq_reg} + (SQ_W+1)'(sqr_reg);
    assign sq_sat  = sq_wide[SQ_W] ? '1 : sq_wide[SQ_W-1:0];

    assign smag     = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;
    assign nq_diff  = (MUL_W+1)'(nq_reg) - {1'b0, mul_acc_reg};
    assign b_val    = {mul_acc_reg, 8'b0} - {6'b0, mul_acc_reg, 2'b0};
    assign rt_trial = rt_res_reg + rt_bit_reg;

    assign tr_val = (!rneg_reg && div_q[QUO_W-1:TR_W-1] != '0) ? TR_MAX
                  : (rneg_reg ? -div_q[TR_W-1:0] : div_q[TR_W-1:0]);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next    = state_reg;
        cap_next      = cfg_wr_en ? cfg_wr_data : cap_reg;
        peak_next     = peak_reg;
        prev_next     = prev_reg;
        have_next     = have_reg;
        worst_next    = worst_reg;
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        sq_next       = sq_reg;
        pfault_next   = pfault_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        mode_next     = mode_reg;
        eq_next       = eq_reg;
        rneg_next     = rneg_reg;
        mag_next      = mag_reg;
        sqr_next      = sqr_reg;
        tr_next       = tr_reg;
        sh_next       = sh_reg;
        fault_next    = fault_reg;
        sneg_next     = sneg_reg;
        nq_next       = nq_reg;
        mul_acc_next  = mul_acc_reg;
        mul_cand_next = mul_cand_reg;
        mul_plr_next  = mul_plr_reg;
        mul_cnt_next  = mul_cnt_reg;
        rt_x_next     = rt_x_reg;
        rt_res_next   = rt_res_reg;
        rt_bit_next   = rt_bit_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        div_ctl       = '0;
        div_dvd       = '0;
        div_dsr       = '0;
        clear_run     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next  = s_tuser;
                    eq_next    = s_tdata[EQ_W-1:0];
                    state_next = (s_tuser inside {MODE_SAMPLE, MODE_FINAL})
                               ? ST_SAMPLE : ST_FIN;
                end
            end
            ST_SAMPLE: begin
                if (!have_reg) begin
                    peak_next  = eq_reg;
                    state_next = ST_DD;
                end else begin
                    if (eq_reg > peak_reg) begin
                        peak_next = eq_reg;
                    end
                    if (prev_reg != '0 && cnt_reg < CNT_LIMIT) begin
                        rneg_next     = eq_lt_prev;
                        div_ctl.start = 1'b1;
                        div_dvd       = {QUO_W'({ret_diff, {RFRAC_W{1'b0}}}),
                                         {(DVD_W-QUO_W){1'b0}}};
                        div_dsr       = DSR_W'(prev_reg);
                        state_next    = ST_RDIV;
                    end else begin
                        state_next = ST_DD;
                    end
                end
            end
            ST_RDIV: begin
                if (div_sts.done) begin
                    mag_next   = ret_mag;
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                sum_next   = sum_sat;
                sqr_next   = mag_reg * mag_reg;
                state_next = ST_SQADD;
            end
            ST_SQADD: begin
                sq_next    = sq_sat;
                state_next = ST_DD;
            end
            ST_DD: begin
                if (peak_reg == '0) begin
                    pfault_next = 1'b1;
                    state_next  = ST_COMMIT;
                end else begin
                    div_ctl.start = 1'b1;
                    div_dvd       = {QUO_W'({dd_d, {FRAC_W{1'b0}}}), {(DVD_W-QUO_W){1'b0}}};
                    div_dsr       = DSR_W'(peak_reg);
                    state_next    = ST_DDIV;
                end
            end
            ST_DDIV: begin
                if (div_sts.done) begin
                    if (div_q[DD_W-1:0] > worst_reg) begin
                        worst_next = div_q[DD_W-1:0];
                    end
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                prev_next  = eq_reg;
                have_next  = 1'b1;
                state_next = (mode_reg == MODE_SAMPLE) ? ST_IDLE : ST_FIN;
            end
            ST_FIN: begin
                tr_next    = '0;
                sh_next    = '0;
                fault_next = 1'b0;
                if (!have_reg) begin
                    state_next = ST_OUT;
                end else begin
                    fault_next = pfault_reg;
                    if (cap_reg == '0) begin
                        fault_next = 1'b1;
                        state_next = ST_SHARPE;
                    end else begin
                        rneg_next     = fin_neg;
                        div_ctl.start = 1'b1;
                        div_dvd       = {QUO_W'({fin_mag, {FRAC_W{1'b0}}}),
                                         {(DVD_W-QUO_W){1'b0}}};
                        div_dsr       = DSR_W'(cap_reg);
                        state_next    = ST_TDIV;
                    end
                end
            end
            ST_TDIV: begin
                if (div_sts.done) begin
                    tr_next    = tr_val;
                    state_next = ST_SHARPE;
                end
            end
            ST_SHARPE: begin
                sneg_next = sum_reg[SUM_W-1];
                if (cnt_reg < CNT_W'(2)) begin
                    state_next = ST_OUT;
                end else begin
                    mul_acc_next  = '0;
                    mul_cand_next = sq_reg;
                    mul_plr_next  = {cnt_reg, {(SUM_W-CNT_W){1'b0}}};
                    mul_cnt_next  = MCNT_W'(CNT_W);
                    state_next    = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (mul_cnt_reg == '0) begin
                    nq_next       = mul_acc_reg[NQ_W-1:0];
                    mul_acc_next  = '0;
                    mul_cand_next = SQ_W'(smag);
                    mul_plr_next  = smag;
                    mul_cnt_next  = MCNT_W'(SUM_W);
                    state_next    = ST_MUL2;
                end else begin
                    mul_acc_next = {mul_acc_reg[MUL_W-2:0], 1'b0}
                                 + (mul_plr_reg[SUM_W-1] ? MUL_W'(mul_cand_reg) : '0);
                    mul_plr_next = {mul_plr_reg[SUM_W-2:0], 1'b0};
                    mul_cnt_next = mul_cnt_reg - 1'b1;
                end
            end
            ST_MUL2: begin
                if (mul_cnt_reg == '0) begin
                    state_next = ST_DIFF;
                end else begin
                    mul_acc_next = {mul_acc_reg[MUL_W-2:0], 1'b0}
                                 + (mul_plr_reg[SUM_W-1] ? MUL_W'(mul_cand_reg) : '0);
                    mul_plr_next = {mul_plr_reg[SUM_W-2:0], 1'b0};
                    mul_cnt_next = mul_cnt_reg - 1'b1;
                end
            end
            ST_DIFF: begin
                if (nq_diff[MUL_W] || nq_diff[MUL_W-1:0] == '0) begin
                    state_next = ST_OUT;
                end else begin
                    div_ctl.start    = 1'b1;
                    div_ctl.long_run = 1'b1;
                    div_dvd          = DVD_W'(b_val);
                    div_dsr          = nq_diff[DSR_W-1:0];
                    state_next       = ST_SDIV;
                end
            end
            ST_SDIV: begin
                if (div_sts.done) begin
                    if (div_sts.big) begin
                        sh_next    = sneg_reg ? SH_MIN : SH_MAX;
                        state_next = ST_OUT;
                    end else begin
                        rt_x_next   = div_q[RT_W-1:0];
                        rt_res_next = '0;
                        rt_bit_next = {1'b1, {(RT_W-1){1'b0}}};
                        state_next  = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                if (rt_bit_reg == '0) begin
                    sh_next    = sneg_reg ? -rt_res_reg[SH_W-1:0] : rt_res_reg[SH_W-1:0];
                    state_next = ST_OUT;
                end else begin
                    if (rt_x_reg >= rt_trial) begin
                        rt_x_next   = rt_x_reg - rt_trial;
                        rt_res_next = (rt_res_reg >> 1) + rt_bit_reg;
                    end else begin
                        rt_res_next = rt_res_reg >> 1;
                    end
                    rt_bit_next = rt_bit_reg >> 2;
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({sh_reg, worst_reg, tr_reg});
                    m_tuser_next  = fault_reg;
                    clear_run     = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (clear_run) begin
            peak_next   = '0;
            prev_next   = '0;
            have_next   = 1'b0;
            worst_next  = '0;
            cnt_next    = '0;
            sum_next    = '0;
            sq_next     = '0;
            pfault_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_reg      <= CAP_RESET;
            peak_reg     <= '0;
            prev_reg     <= '0;
            have_reg     <= 1'b0;
            worst_reg    <= '0;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            sq_reg       <= '0;
            pfault_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            peak_reg     <= peak_next;
            prev_reg     <= prev_next;
            have_reg     <= have_next;
            worst_reg    <= worst_next;
            cnt_reg      <= cnt_next;
            sum_reg      <= sum_next;
            sq_reg       <= sq_next;
            pfault_reg   <= pfault_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        eq_reg       <= eq_next;
        rneg_reg     <= rneg_next;
        mag_reg      <= mag_next;
        sqr_reg      <= sqr_next;
        tr_reg       <= tr_next;
        sh_reg       <= sh_next;
        fault_reg    <= fault_next;
        sneg_reg     <= sneg_next;
        nq_reg       <= nq_next;
        mul_acc_reg  <= mul_acc_next;
        mul_cand_reg <= mul_cand_next;
        mul_plr_reg  <= mul_plr_next;
        mul_cnt_reg  <= mul_cnt_next;
        rt_x_reg     <= rt_x_next;
        rt_res_reg   <= rt_res_next;
        rt_bit_reg   <= rt_bit_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

endmodule

/* design/ecrm_checker.sv */
// Port-level checker for the risk metrics block, bound to the top level.
`include "equity_curve_risk_metrics_macros.svh"

module ecrm_checker import ecrm_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [MODE_W-1:0]    s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    `ECRM_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result beat changed")
    `ECRM_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_W-1:M_PAD_LSB] == '0, "result pad bits not zero")
    `ECRM_ASSERT_NOW(a_dd_range, aclk, aresetn, m_tvalid, m_tdata[DD_HI:DD_LO] <= DD_ONE, "drawdown above one")
    `ECRM_ASSERT_NEXT(a_sample_quiet, aclk, aresetn, s_tvalid && s_tready && s_tuser == MODE_SAMPLE && !m_tvalid, !m_tvalid, "plain sample produced a result")
    `ECRM_ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready, !s_tready, "input ready right after a beat")

endmodule

bind equity_curve_risk_metrics ecrm_checker u_ecrm_checker (.*);
